// ===== hdl/sha_pkg.sv =====
// SHA-256 stream hasher package: controller state type, command/status structs,
// round constant table and round/schedule helper functions. No dependencies.
package sha_pkg;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [5:0] PAD_LEN_OFS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a word
    ST_BYTE,   // put one byte into the buffer
    ST_ROUND,  // one compression round
    ST_FOLD,   // add working vars into hash
    ST_PAD,    // put one padding/length byte
    ST_EMIT    // present digest words
  } sha_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_word;   // latch input word
    logic       put_byte;    // write one byte into buffer
    logic [1:0] byte_sel;    // source: 0 data, 1 0x80, 2 zero, 3 length
    logic [1:0] data_byte;   // which byte of the held word
    logic [2:0] len_byte;    // which byte of the bit length
    logic       count_len;   // count one message byte
    logic       start_comp;  // copy hash into working vars
    logic       do_round;
    logic       fold;
    logic       rearm;       // restore initial hash, clear length/fill
  } sha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] fill;
    logic       block_full;  // fill wrapped after last put
    logic [5:0] round;
  } sha_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/sha_datapath.sv =====
// SHA-256 datapath: block buffer / schedule window, working variables, hash
// words, fill and length counters, digest word select. Uses sha_pkg.
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  output sha_pkg::sha_stat_t stat,
  input  logic [31:0]       in_word,
  input  logic [2:0]        emit_idx,
  output logic [31:0]       hash_word
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [31:0] word_r;
  logic [5:0]  fill_r;
  logic [60:0] len_r;
  logic [5:0]  round_r;
  logic        full_r;

  logic [63:0] bits;
  logic [7:0]  byte_val;
  logic [31:0] w_cur, t1, t2;
  logic [3:0]  r4;

  assign bits = {len_r, 3'b000};
  assign r4 = round_r[3:0];

  always_comb begin
    unique case (cmd.byte_sel)
      2'd0: byte_val = word_r[5'(24 - 8 * cmd.data_byte) +: 8];
      2'd1: byte_val = 8'h80;
      2'd2: byte_val = 8'h00;
      default: byte_val = bits[6'(56 - 8 * cmd.len_byte) +: 8];
    endcase
  end

  always_comb begin
    if (round_r[5:4] != 2'b00) begin
      w_cur = w_r[r4] + sha_pkg::sig0(w_r[r4 + 4'd1]) + w_r[r4 + 4'd9]
            + sha_pkg::sig1(w_r[r4 + 4'd14]);
    end else begin
      w_cur = w_r[r4];
    end
    t1 = v_r[7] + (sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11)
         ^ sha_pkg::rotr(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha_pkg::ROUND_K[round_r] + w_cur;
    t2 = (sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13)
         ^ sha_pkg::rotr(v_r[0], 22)) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2])
         ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      word_r <= in_word;
    end
    if (cmd.put_byte) begin
      w_r[fill_r[5:2]][5'(24 - 8 * fill_r[1:0]) +: 8] <= byte_val;
    end
    if (cmd.start_comp) begin
      v_r <= h_r;
    end
    if (cmd.do_round) begin
      w_r[r4] <= w_cur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= sha_pkg::INIT_H;
      fill_r  <= '0;
      len_r   <= '0;
      round_r <= '0;
      full_r  <= 1'b0;
    end else begin
      full_r <= cmd.put_byte && (fill_r == 6'd63);
      if (cmd.put_byte) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_len) begin
        len_r <= len_r + 61'd1;
      end
      if (cmd.do_round) begin
        round_r <= round_r + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (cmd.rearm) begin
        h_r    <= sha_pkg::INIT_H;
        fill_r <= '0;
        len_r  <= '0;
      end
    end
  end

  assign stat.fill       = fill_r;
  assign stat.block_full = full_r;
  assign stat.round      = round_r;
  assign hash_word       = h_r[emit_idx];

endmodule

// ===== hdl/sha_controller.sv =====
// SHA-256 controller: sequences byte loads, rounds, padding and digest output.
// Uses sha_pkg; drives sha_datapath through sha_cmd_t.
module sha_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_byte_count,
  input  logic               in_last_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         emit_idx,
  output sha_pkg::sha_cmd_t  cmd,
  input  sha_pkg::sha_stat_t stat
);

  sha_pkg::sha_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;     // bytes left in word
  logic [1:0] pos_r, pos_nxt;     // next byte in word
  logic       last_r, last_nxt;
  logic       pad_r, pad_nxt;     // 0x80 already placed
  logic       ext_r, ext_nxt;     // 0x80 landed in the length slot: zero-fill this block
  logic [2:0] idx_r, idx_nxt;     // emit / length byte index
  logic       resume_r, resume_nxt; // after fold: 0 to bytes, 1 to padding
  logic       pad_done_r, pad_done_nxt;
  logic [2:0] cnt_in;
  logic       acc;

  assign acc    = in_valid && in_ready;
  assign cnt_in = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;

  // next state
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    pad_nxt    = pad_r;
    ext_nxt    = ext_r;
    idx_nxt    = idx_r;
    resume_nxt = resume_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (acc) begin
          cnt_nxt   = cnt_in;
          pos_nxt   = 2'd0;
          last_nxt  = in_last_word;
          pad_nxt   = 1'b0;
          ext_nxt   = 1'b0;
          idx_nxt   = 3'd0;
          state_nxt = sha_pkg::ST_BYTE;
        end
      end
      sha_pkg::ST_BYTE: begin
        if (stat.block_full) begin
          resume_nxt = 1'b0;
          state_nxt  = sha_pkg::ST_ROUND;
        end else if (cnt_r != 3'd0) begin
          cnt_nxt = cnt_r - 3'd1;
          pos_nxt = pos_r + 2'd1;
        end else if (last_r) begin
          state_nxt = sha_pkg::ST_PAD;
        end else begin
          state_nxt = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_ROUND: begin
        if (stat.round == 6'd63) begin
          state_nxt = sha_pkg::ST_FOLD;
        end
      end
      sha_pkg::ST_FOLD: begin
        if (resume_r && pad_r && idx_r == 3'd0 && stat.fill == 6'd0
            && pad_done_r) begin
          state_nxt = sha_pkg::ST_EMIT;
        end else begin
          state_nxt = resume_r ? sha_pkg::ST_PAD : sha_pkg::ST_BYTE;
        end
      end
      sha_pkg::ST_PAD: begin
        if (stat.block_full) begin
          resume_nxt = 1'b1;
          ext_nxt    = 1'b0;
          state_nxt  = sha_pkg::ST_ROUND;
        end else if (!pad_r) begin
          pad_nxt = 1'b1;
          if (stat.fill >= sha_pkg::PAD_LEN_OFS) begin
            ext_nxt = 1'b1;
          end
        end else if (!ext_r && stat.fill >= sha_pkg::PAD_LEN_OFS) begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      sha_pkg::ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  // padding finished once the final length byte went in (fill wrapped)
  always_comb begin
    pad_done_nxt = pad_done_r;
    if (state_r == sha_pkg::ST_IDLE) begin
      pad_done_nxt = 1'b0;
    end else if (state_r == sha_pkg::ST_PAD && pad_r && !ext_r && stat.fill == 6'd63
                 && !stat.block_full) begin
      pad_done_nxt = 1'b1;
    end
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    emit_idx  = idx_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_word = 1'b1;
      end
      sha_pkg::ST_BYTE: begin
        if (stat.block_full) begin
          cmd.start_comp = 1'b1;
        end else if (cnt_r != 3'd0) begin
          cmd.put_byte  = 1'b1;
          cmd.count_len = 1'b1;
          cmd.data_byte = pos_r;
          cmd.byte_sel  = 2'd0;
        end
      end
      sha_pkg::ST_ROUND: cmd.do_round = 1'b1;
      sha_pkg::ST_FOLD:  cmd.fold     = 1'b1;
      sha_pkg::ST_PAD: begin
        if (stat.block_full) begin
          cmd.start_comp = 1'b1;
        end else if (!pad_done_r) begin
          cmd.put_byte = 1'b1;
          cmd.len_byte = idx_r;
          if (!pad_r) begin
            cmd.byte_sel = 2'd1;
          end else if (!ext_r && stat.fill >= sha_pkg::PAD_LEN_OFS) begin
            cmd.byte_sel = 2'd3;
          end else begin
            cmd.byte_sel = 2'd2;
          end
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && idx_r == 3'd7) begin
          cmd.rearm = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha_pkg::ST_IDLE;
      cnt_r      <= '0;
      pos_r      <= '0;
      last_r     <= 1'b0;
      pad_r      <= 1'b0;
      ext_r      <= 1'b0;
      idx_r      <= '0;
      resume_r   <= 1'b0;
      pad_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      last_r     <= last_nxt;
      pad_r      <= pad_nxt;
      ext_r      <= ext_nxt;
      idx_r      <= idx_nxt;
      resume_r   <= resume_nxt;
      pad_done_r <= pad_done_nxt;
    end
  end

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// Streaming SHA-256 hasher top level: controller plus datapath.
// Depends on sha_pkg, sha_controller and sha_datapath.
//
// Input channel (in_valid/in_ready): one big-endian message word per
// transaction, in_byte_count leading bytes valid (values above 4 count as 4),
// in_last_word closes the message and starts padding.
// Result channel (out_valid/out_ready): after a last word, eight transactions
// carry digest words 0..7; out_last_digest_word marks word 7. The hash then
// re-arms to the initial values for the next message.
// Sequence: a word takes an accept step, then its bytes go into the buffer one
// per cycle (paused while a full block is compressed) and a closing step returns
// to idle. Each full block adds a setup step, 64 rounds of the single shared
// round unit and a fold step.
// A last word then adds the pad bytes (up to 72 when the length spills into an
// extra block) and a setup, round and fold pass per padded block, then eight
// digest transactions.
// Only one item is in flight: in_ready is low while a word is processed and
// while digest words wait. A stalled receiver holds the current digest word
// and index stable until taken. Reset (rst_n low, synchronous) loads the
// initial hash and clears length, fill and controller state.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_digest_word
);

  sha_pkg::sha_cmd_t  cmd;
  sha_pkg::sha_stat_t stat;
  logic [2:0]         emit_idx;

  sha_controller u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .emit_idx      (emit_idx),
    .cmd           (cmd),
    .stat          (stat)
  );

  sha_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_message_word),
    .emit_idx  (emit_idx),
    .hash_word (out_digest_word)
  );

  assign out_word_index       = emit_idx;
  assign out_last_digest_word = (emit_idx == 3'd7);

  // never take a word while digest words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during digest output");

  // rounds never run together with byte writes
  a_round_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_round |-> !cmd.put_byte) else $error("round and byte write overlap");

  // after the final digest word the block is idle again
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_digest_word) |=> in_ready)
    else $error("not idle after digest");

endmodule

// ===== verif/sha256_digest_checker.sv =====
// Digest checker for the streaming SHA-256 hasher: watches both channels,
// computes the expected digest words and compares them. Uses no package.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_digest_word,
  output int          fail_count,
  output int          pending_count,
  output int          digest_count
);

  localparam logic [31:0] H0 [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };
  localparam logic [31:0] KTAB [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   block_buf [64];
  int           fill;
  logic [60:0]  msg_len;
  digest_word_t expected_digests [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic append_byte(input logic [7:0] b);
    block_buf[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  // Absorb one accepted word; on the last word pad, finish and queue the digest.
  task automatic absorb_word(input logic [31:0] word, input logic [2:0] cnt,
                             input logic is_last);
    int n;
    logic [63:0] bit_len;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (int i = 0; i < n; i++) begin
      append_byte(word[31 - 8*i -: 8]);
      msg_len = msg_len + 61'd1;
    end
    if (is_last) begin
      bit_len = {msg_len, 3'b000};
      append_byte(8'h80);
      while (fill != 56) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++)
        expected_digests.push_back('{hash_state[i], 3'(i), i == 7});
      for (int i = 0; i < 8; i++) hash_state[i] = H0[i];
      fill = 0;
      msg_len = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_state[i] = H0[i];
      fill = 0;
      msg_len = '0;
      expected_digests.delete();
      fail_count = 0;
      digest_count = 0;
    end else begin
      if (in_valid && in_ready) absorb_word(in_message_word, in_byte_count, in_last_word);
      if (out_valid && out_ready) begin
        digest_count++;
        if (expected_digests.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest transaction word=%h index=%0d", $time,
                   out_digest_word, out_word_index);
        end else begin
          exp_w = expected_digests.pop_front();
          if (out_digest_word !== exp_w.digest) begin
            fail_count++;
            $display("%0t: digest word mismatch expected %h actual %h", $time,
                     exp_w.digest, out_digest_word);
          end
          if (out_word_index !== exp_w.index) begin
            fail_count++;
            $display("%0t: word index mismatch expected %0d actual %0d", $time,
                     exp_w.index, out_word_index);
          end
          if (out_last_digest_word !== exp_w.last) begin
            fail_count++;
            $display("%0t: last flag mismatch expected %b actual %b", $time,
                     exp_w.last, out_last_digest_word);
          end
        end
      end
    end
    pending_count = expected_digests.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    digest_count = 0;
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the SHA-256 stream hasher testbench: clock, reset, stimulus and verdict.
// Depends on sha256_stream_hasher (and sha_pkg) and sha256_digest_checker.
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_message_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_digest_word;

  int fail_count, pending_count, digest_count;
  int cycle_count = 0;
  int send_idle_pct = 7;   // percent of cycles the sender holds off
  int recv_idle_pct = 75;  // percent of cycles the receiver holds off
  bit recv_hold = 1'b0;    // long receiver stall for back-pressure
  int words_sent = 0;
  int messages_sent = 0;

  localparam int CYCLE_LIMIT = 600000;

  always #1 clk = ~clk;

  sha256_stream_hasher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_message_word(in_message_word), .in_byte_count(in_byte_count),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_digest_word(out_last_digest_word)
  );

  sha256_digest_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_message_word(in_message_word), .in_byte_count(in_byte_count),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_digest_word(out_last_digest_word),
    .fail_count(fail_count), .pending_count(pending_count), .digest_count(digest_count)
  );

  // Hard stop: the run must finish well before this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycle_count, pending_count);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: randomly drop ready, or hold it low for the whole hold-off.
  always @(negedge clk) begin
    if (!rst_n || recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one word and hold it until the transaction completes; valid stays
  // up after the transaction so the next word can follow without a gap.
  task automatic send_word(input logic [31:0] word, input logic [2:0] cnt,
                           input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_message_word <= word;
    in_byte_count <= cnt;
    in_last_word <= is_last;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (is_last) messages_sent++;
  endtask

  // Random message: mostly full words, some short ones, a closing word of random byte count.
  task automatic send_message(input int nwords);
    for (int i = 0; i < nwords; i++) begin
      if (i == nwords - 1)
        send_word($urandom, 3'($urandom_range(7)), 1'b1);
      else if ($urandom_range(9) == 0)
        send_word($urandom, 3'($urandom_range(7)), 1'b0);
      else
        send_word($urandom, 3'd4, 1'b0);
    end
  endtask

  task automatic send_random_messages(input int total_words);
    int n, target;
    target = words_sent + total_words;
    while (words_sent < target) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      send_message(n);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message, several closing byte counts, oversized counts.
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(32'hA5A5_A5A5, 3'd1, 1'b1);
    send_word(32'h5A5A_5A5A, 3'd2, 1'b0);
    send_word(32'h1234_5678, 3'd5, 1'b0);
    send_word(32'h9ABC_DEF0, 3'd6, 1'b1);
    // 56-byte message forces the extra padding block; then a 12-byte message closed by an empty word.
    for (int i = 0; i < 14; i++) send_word(32'hFFFF_FFFF, 3'd4, i == 13);
    for (int i = 0; i < 3; i++) send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'h8000_0001, 3'd0, 1'b1);

    send_random_messages(70);

    // Long receiver hold-off while words keep coming, so the input stalls.
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(negedge clk);
        recv_hold = 1'b0;
      end
      send_random_messages(10);
    join

    send_idle_pct = 75;
    recv_idle_pct = 7;
    send_random_messages(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_messages(60);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d words in %0d messages, checked %0d digest words",
             words_sent, messages_sent, digest_count);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
